FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lpfp_pkg.sv
// Shared types and constants of the length-prefixed frame parser.
package lpfp_pkg;

    localparam logic [1:0] EV_BEGIN = 2'd0;
    localparam logic [1:0] EV_BODY  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  body_byte;
        logic        last_of_run;
        logic [7:0]  msg_version;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [31:0] msg_corr_id;
        logic [31:0] body_length;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

FILE: rtl/core/lpfp_core.sv
// Input register and per-byte header and body state update of the parser.
`include "assert_macros.svh"

module lpfp_core #(
    parameter int VERSION_BYTES = 1,
    parameter int TYPE_BYTES    = 1,
    parameter int FLAGS_BYTES   = 1,
    parameter int CORR_BYTES    = 4,
    parameter int LEN_BYTES     = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_space_ok,
    output lpfp_pkg::t_push o_push
);
    import lpfp_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_VERSION = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_FLAGS   = 3'd3;
    localparam logic [2:0] PH_CORR    = 3'd4;
    localparam logic [2:0] PH_LEN     = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;

    localparam logic [3:0] VB = 4'(VERSION_BYTES);
    localparam logic [3:0] TB = 4'(TYPE_BYTES);
    localparam logic [3:0] FB = 4'(FLAGS_BYTES);
    localparam logic [3:0] CB = 4'(CORR_BYTES);
    localparam logic [3:0] LB = 4'(LEN_BYTES);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_ver, n_ver;
    logic [7:0]  r_typ, n_typ;
    logic [7:0]  r_flg, n_flg;
    logic [31:0] r_cor, n_cor;
    logic [31:0] r_len, n_len;
    logic [31:0] r_cnt, n_cnt;
    logic        fire;
    logic [2:0]  hdr_phase;
    logic [2:0]  hdr_idx;
    logic [3:0]  fld_bytes;
    logic        fld_last;
    t_push       push;

    function automatic logic [7:0] merge8(logic [7:0] cur, logic [7:0] b, logic [2:0] idx);
        return (idx == 3'd0) ? (cur | b) : cur;
    endfunction

    function automatic logic [31:0] merge32(logic [31:0] cur, logic [7:0] b, logic [2:0] idx);
        return idx[2] ? cur : (cur | (32'(b) << {idx[1:0], 3'b000}));
    endfunction

    function automatic t_result mk(logic [1:0] kind, logic [7:0] data, logic last,
                                   logic [7:0] ver, logic [7:0] typ, logic [7:0] flg,
                                   logic [31:0] cor, logic [31:0] len);
        t_result r;
        r.event_kind     = kind;
        r.body_byte      = data;
        r.last_of_run    = last;
        r.msg_version    = ver;
        r.msg_type       = typ;
        r.msg_flags      = flg;
        r.msg_corr_id    = cor;
        r.body_length    = len;
        return r;
    endfunction

    assign fire       = r_in_valid && i_space_ok;
    assign o_in_ready = !r_in_valid || fire;
    assign o_push     = push;

    assign hdr_phase = (r_phase == PH_IDLE) ? PH_VERSION : r_phase;
    assign hdr_idx   = (r_phase == PH_IDLE) ? 3'd0 : r_idx;

    always_comb begin
        case (hdr_phase)
            PH_VERSION: fld_bytes = VB;
            PH_TYPE:    fld_bytes = TB;
            PH_FLAGS:   fld_bytes = FB;
            PH_CORR:    fld_bytes = CB;
            default:    fld_bytes = LB;
        endcase
        fld_last = ({1'b0, hdr_idx} + 4'd1) >= fld_bytes;
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_ver   = r_ver;
        n_typ   = r_typ;
        n_flg   = r_flg;
        n_cor   = r_cor;
        n_len   = r_len;
        n_cnt   = r_cnt;
        push    = '0;
        if (r_phase == PH_IDLE) begin
            n_ver   = '0;
            n_typ   = '0;
            n_flg   = '0;
            n_cor   = '0;
            n_len   = '0;
            n_cnt   = '0;
            n_idx   = '0;
            n_phase = PH_VERSION;
            push.res0  = mk(EV_BEGIN, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0);
            push.count = 2'd1;
        end
        if (n_phase inside {[PH_VERSION:PH_LEN]}) begin
            case (n_phase)
                PH_VERSION: n_ver = merge8(n_ver, r_in_byte, n_idx);
                PH_TYPE:    n_typ = merge8(n_typ, r_in_byte, n_idx);
                PH_FLAGS:   n_flg = merge8(n_flg, r_in_byte, n_idx);
                PH_CORR:    n_cor = merge32(n_cor, r_in_byte, n_idx);
                default:    n_len = merge32(n_len, r_in_byte, n_idx);
            endcase
            if (fld_last) begin
                n_idx = '0;
                if (n_phase == PH_LEN) begin
                    n_phase = PH_BODY;
                    if (n_len == 32'd0) begin
                        n_phase    = PH_IDLE;
                        push.res0  = mk(EV_END, 8'd0, 1'b1, n_ver, n_typ, n_flg, n_cor, n_len);
                        push.count = 2'd1;
                    end
                end else begin
                    n_phase = n_phase + 3'd1;
                end
            end else begin
                n_idx = n_idx + 3'd1;
            end
        end else if (n_phase == PH_BODY) begin
            n_cnt = r_cnt + 32'd1;
            if (n_cnt >= r_len) begin
                n_phase    = PH_IDLE;
                push.res0  = mk(EV_BODY, r_in_byte, 1'b0, r_ver, r_typ, r_flg, r_cor, r_len);
                push.res1  = mk(EV_END, 8'd0, 1'b1, r_ver, r_typ, r_flg, r_cor, r_len);
                push.count = 2'd2;
            end else begin
                push.res0  = mk(EV_BODY, r_in_byte, 1'b1, r_ver, r_typ, r_flg, r_cor, r_len);
                push.count = 2'd1;
            end
        end else begin
            n_phase = PH_IDLE;
            n_idx   = '0;
        end
        if (!fire) begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_idx      <= '0;
            r_ver      <= '0;
            r_typ      <= '0;
            r_flg      <= '0;
            r_cor      <= '0;
            r_len      <= '0;
            r_cnt      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_ver   <= n_ver;
                r_typ   <= n_typ;
                r_flg   <= n_flg;
                r_cor   <= n_cor;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    `ASSERT_IMPLIES(a_begin_single, i_clk, i_rst_n, fire && (r_phase == PH_IDLE), push.count == 2'd1 && push.res0.event_kind == EV_BEGIN, "Begin byte must give exactly one result.")
    `ASSERT_NEXT(a_end_to_idle, i_clk, i_rst_n, fire && (push.count == 2'd2), r_phase == PH_IDLE, "Message end must return to idle.")
    `ASSERT_IMPLIES(a_push_needs_fire, i_clk, i_rst_n, push.count != 2'd0, fire && i_space_ok, "Results pushed without a transaction in process.")

endmodule

FILE: rtl/core/lpfp_fifo.sv
// Result queue that takes up to two results per cycle and releases one while the reader is ready.
`include "assert_macros.svh"

module lpfp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpfp_pkg::t_push   i_push,
    output logic              o_space_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output lpfp_pkg::t_result o_result
);
    import lpfp_pkg::*;

    localparam logic [FIFO_AW:0] DEPTH = (FIFO_AW + 1)'(FIFO_DEPTH);

    t_result             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_AW:0]    r_count, n_count;
    logic                pop;

    assign o_valid    = r_count != '0;
    assign o_result   = r_mem[r_rd_ptr];
    assign pop        = o_valid && i_ready;
    assign o_space_ok = r_count <= (DEPTH - 2);
    assign n_count    = r_count + (FIFO_AW + 1)'(i_push.count) - (FIFO_AW + 1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push.res1;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH, "Result queue count exceeds its depth.")
    `ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, i_push.count != 2'd0, r_count <= (DEPTH - 2), "Results pushed into a full queue.")
    `ASSERT_NEXT(a_count_track, i_clk, i_rst_n, pop && (i_push.count == 2'd0), r_count == $past(r_count) - 1'b1, "Queue count did not drop on a pop.")

endmodule

FILE: rtl/core/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser.
// An accepted byte waits in the input register until the result queue has room; its results are then
// written into the queue. Throughput: one byte per cycle while the queue has room; a header byte gives
// at most one result, a byte ending a body two; the single-read queue drains one per cycle when ready.
// Reset: synchronous, active low; the parser returns to idle and the queue empties.
module length_prefixed_frame_parser #(
    parameter int VERSION_BYTES = 1,
    parameter int TYPE_BYTES    = 1,
    parameter int FLAGS_BYTES   = 1,
    parameter int CORR_BYTES    = 4,
    parameter int LEN_BYTES     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_body_byte,
    output logic        o_last_of_run,
    output logic [7:0]  o_msg_version,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_msg_flags,
    output logic [31:0] o_msg_corr_id,
    output logic [31:0] o_body_length
);
    import lpfp_pkg::*;

    t_push   push;
    t_result result;
    logic    space_ok;

    lpfp_core #(
        .VERSION_BYTES(VERSION_BYTES),
        .TYPE_BYTES   (TYPE_BYTES),
        .FLAGS_BYTES  (FLAGS_BYTES),
        .CORR_BYTES   (CORR_BYTES),
        .LEN_BYTES    (LEN_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    lpfp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (result)
    );

    assign o_event_kind     = result.event_kind;
    assign o_body_byte      = result.body_byte;
    assign o_last_of_run    = result.last_of_run;
    assign o_msg_version    = result.msg_version;
    assign o_msg_type       = result.msg_type;
    assign o_msg_flags      = result.msg_flags;
    assign o_msg_corr_id    = result.msg_corr_id;
    assign o_body_length    = result.body_length;

endmodule
